/* rtl/nsdm_pkg.sv */
`timescale 1ns / 1ps

package nsdm_pkg;

    localparam int unsigned POS_W = 31;
    localparam int unsigned OP_W  = 2;
    localparam int unsigned ST_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SH_RD,
        S_SH_WR,
        S_Q_RD_HI,
        S_Q_CAP_HI,
        S_Q_RD_LO,
        S_Q_CAP_LO,
        S_DONE
    } state_t;

endpackage

/* rtl/nearest_sorted_distance_max.sv */
`timescale 1ns / 1ps

// sorted position store with nearest-neighbor query and running maximum distance.
// each beat on the item channel carries an operation (clear, add, query) and a
// position; each one gives exactly one beat on the result channel with a status,
// the nearest distance and the running maximum (radius). positions live in a
// store of STORE_DEPTH entries with one write port and one registered read port,
// used one access per cycle under a small sequencer, so the block takes one item
// at a time and item_ready is high only while the sequencer is idle. a clear or an
// unused code goes from accept straight to the done state. a query runs a binary
// search with a read and then a compare per probe, then reads the neighbors on each
// side. an add runs the same search and then moves every entry above the insertion
// point up by one, a read then a write per moved entry; this shift dominates the
// rate when loading positions in descending order. a full store drops the add and
// reports status full; a query on an empty store reports status empty. the finished
// result sits in an output register, so the next item is taken while it waits; the
// sequencer only holds when a second result is ready first.
module nearest_sorted_distance_max
    import nsdm_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [OP_W-1:0]  operation,
    input  logic [POS_W-1:0] position,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [ST_W-1:0]  status,
    output logic [POS_W-1:0] nearest_distance,
    output logic [POS_W-1:0] radius
);

    // address width of the store and width of a count that can hold STORE_DEPTH
    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [POS_W-1:0] max_reg, max_next;
    logic [POS_W-1:0] dist_reg, dist_next;
    logic             have_hi_reg, have_hi_next;
    logic [ST_W-1:0]  stat_reg, stat_next;

    // result beat register
    logic             res_valid_reg, res_valid_next;
    logic [ST_W-1:0]  res_status_reg, res_status_next;
    logic [POS_W-1:0] res_dist_reg, res_dist_next;
    logic [POS_W-1:0] res_radius_reg, res_radius_next;

    // store port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [POS_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [POS_W-1:0] mem_rdata;

    logic [CW-1:0]    mid;
    logic [POS_W-1:0] d_lo;
    logic             go_right;
    logic             res_free;
    logic [CW-1:0]    idx_dec;
    logic [CW-1:0]    lo_dec;

    nsdm_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared datapath pieces: probe midpoint, compare, lower distance
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = (op_reg == OP_ADD) ? (mem_rdata <= pos_reg) : (mem_rdata < pos_reg);
    assign d_lo     = pos_reg - mem_rdata;
    assign idx_dec  = idx_reg - CW'(1);
    assign lo_dec   = lo_reg - CW'(1);
    assign res_free = !res_valid_reg || result_ready;

    assign item_ready       = (state_reg == S_IDLE);
    assign result_valid     = res_valid_reg;
    assign status           = res_status_reg;
    assign nearest_distance = res_dist_reg;
    assign radius           = res_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        idx_reg        <= idx_next;
        dist_reg       <= dist_next;
        have_hi_reg    <= have_hi_next;
        stat_reg       <= stat_next;
        res_status_reg <= res_status_next;
        res_dist_reg   <= res_dist_next;
        res_radius_reg <= res_radius_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        max_next        = max_reg;
        dist_next       = dist_reg;
        have_hi_next    = have_hi_reg;
        stat_next       = stat_reg;
        res_valid_next  = res_valid_reg && !result_ready;
        res_status_next = res_status_reg;
        res_dist_next   = res_dist_reg;
        res_radius_next = res_radius_reg;
        mem_we          = 1'b0;
        mem_waddr       = lo_reg[AW-1:0];
        mem_wdata       = pos_reg;
        mem_re          = 1'b0;
        mem_raddr       = mid[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next   = operation;
                    pos_next  = position;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    idx_next  = count_reg;
                    dist_next = '0;
                    stat_next = ST_OK;
                    priority if (operation == OP_CLEAR)
                    begin
                        count_next = '0;
                        max_next   = '0;
                        state_next = S_DONE;
                    end
                    else if (operation == OP_ADD)
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SRCH_RD;
                        end
                    end
                    else if (operation == OP_QUERY)
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next  = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SRCH_RD;
                        end
                    end
                    else
                    begin
                        // unused code: store left unchanged
                        state_next = S_DONE;
                    end
                end
            end

            // binary search: lo ends at first entry > pos (add) or >= pos (query)
            S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid[AW-1:0];
                    state_next = S_SRCH_CMP;
                end
                else if (op_reg == OP_ADD)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_Q_RD_HI;
                end
            end

            S_SRCH_CMP:
            begin
                if (go_right)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH_RD;
            end

            // move entries above the insertion point up by one, top first
            S_SH_RD:
            begin
                if (idx_reg > lo_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_dec[AW-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = lo_reg[AW-1:0];
                    mem_wdata  = pos_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end

            S_SH_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_dec;
                state_next = S_SH_RD;
            end

            // neighbor at or above the query
            S_Q_RD_HI:
            begin
                have_hi_next = 1'b0;
                if (lo_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = lo_reg[AW-1:0];
                    state_next = S_Q_CAP_HI;
                end
                else
                begin
                    state_next = S_Q_RD_LO;
                end
            end

            S_Q_CAP_HI:
            begin
                dist_next    = mem_rdata - pos_reg;
                have_hi_next = 1'b1;
                state_next   = S_Q_RD_LO;
            end

            // neighbor below the query
            S_Q_RD_LO:
            begin
                if (lo_reg != '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = lo_dec[AW-1:0];
                    state_next = S_Q_CAP_LO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_Q_CAP_LO:
            begin
                if (!have_hi_reg || (d_lo < dist_reg))
                begin
                    dist_next = d_lo;
                end
                state_next = S_DONE;
            end

            // fold distance into the maximum and hand over the result beat
            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = stat_reg;
                    res_dist_next   = dist_reg;
                    if (dist_reg > max_reg)
                    begin
                        max_next        = dist_reg;
                        res_radius_next = dist_reg;
                    end
                    else
                    begin
                        res_radius_next = max_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/nsdm_store.sv */
`timescale 1ns / 1ps

module nsdm_store
    import nsdm_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [POS_W-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [POS_W-1:0] rdata
);

    logic [POS_W-1:0] mem [DEPTH];
    logic [POS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/nsdm_checker.sv */
`timescale 1ns / 1ps

module nsdm_checker
    import nsdm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input logic [ST_W-1:0]  status,
    input logic [POS_W-1:0] nearest_distance,
    input logic [POS_W-1:0] radius
);

    // a pending result beat stays up until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped before accept");

    // an accepted item keeps the sequencer busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while previous item still in work");

    // dropped or empty cases carry no distance
    a_no_dist_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> nearest_distance == '0)
        else $error("distance reported with non-ok status");

    // radius already includes this beat's distance
    a_radius_covers: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> nearest_distance <= radius)
        else $error("radius below reported distance");

endmodule

bind nearest_sorted_distance_max nsdm_checker u_nsdm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .status           (status),
    .nearest_distance (nearest_distance),
    .radius           (radius)
);

/* dv/nearest_sorted_distance_max_test.sv */
`timescale 1ns / 1ps

// checks the sorted position store with nearest-distance queries against an
// in-bench shadow of the store
// every accepted item beat is run through the shadow, which queues the answer it
// should give; every result beat is checked field by field against the oldest answer
// directed tests cover the empty store, position zero and field extremes, then
// random sessions (clear, a burst of adds and queries) run under three idle
// patterns, and one test loads the store to capacity and overflows it
module nearest_sorted_distance_max_test;
    import nsdm_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    // a front insert into a nearly full store moves ~1023 entries, each a read then
    // a write, so a quiet stretch that long is legal; allow far more
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_PRINTED = 20;

    // one result beat as the block should present it
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] nearest;
        logic [POS_W-1:0] radius;
    } nearest_answer_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic             result_valid;
    logic             result_ready;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] nearest_distance;
    logic [POS_W-1:0] radius;

    nearest_sorted_distance_max #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .operation        (operation),
        .position         (position),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .status           (status),
        .nearest_distance (nearest_distance),
        .radius           (radius)
    );

    // shadow of the block state, kept sorted ascending
    logic [POS_W-1:0] shadow_pos [STORE_DEPTH];
    int               shadow_count = 0;
    logic [POS_W-1:0] shadow_radius = '0;

    // answers owed by the block, oldest first
    nearest_answer_t nearest_answers [$];

    // idle odds in percent per cycle, changed between phases
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int errors = 0;
    int beats_checked = 0;
    int items_sent = 0;
    int n_clears = 0;
    int n_adds = 0;
    int n_queries = 0;
    int n_unused = 0;
    int n_dropped = 0;
    int n_empty_queries = 0;
    int peak_count = 0;
    logic [POS_W-1:0] peak_radius = '0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch %0d at %0t: %s", errors, $time, msg);
    endtask

    // applies one accepted item to the shadow and queues the answer it owes
    task automatic answer_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
        nearest_answer_t  ans;
        int               lo;
        int               hi;
        int               mid;
        int               i;
        logic [POS_W-1:0] gap_up;
        logic [POS_W-1:0] gap_down;
        ans.status = ST_OK;
        ans.nearest = '0;
        items_sent++;
        case (op)
            OP_CLEAR:
            begin
                n_clears++;
                shadow_count = 0;
                shadow_radius = '0;
            end
            OP_ADD:
            begin
                n_adds++;
                if (shadow_count >= STORE_DEPTH)
                begin
                    ans.status = ST_FULL;
                    n_dropped++;
                end
                else
                begin
                    // insertion point sits after any equal entries
                    lo = 0;
                    hi = shadow_count;
                    while (lo < hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (shadow_pos[mid] <= pos)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    for (i = shadow_count; i > lo; i--)
                        shadow_pos[i] = shadow_pos[i - 1];
                    shadow_pos[lo] = pos;
                    shadow_count++;
                    if (shadow_count > peak_count)
                        peak_count = shadow_count;
                end
            end
            OP_QUERY:
            begin
                n_queries++;
                if (shadow_count == 0)
                begin
                    ans.status = ST_EMPTY;
                    n_empty_queries++;
                end
                else
                begin
                    // first entry not below the query
                    lo = 0;
                    hi = shadow_count;
                    while (lo < hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (shadow_pos[mid] < pos)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    if (lo == shadow_count)
                        ans.nearest = pos - shadow_pos[lo - 1];
                    else if (lo == 0)
                        ans.nearest = shadow_pos[0] - pos;
                    else
                    begin
                        gap_up = shadow_pos[lo] - pos;
                        gap_down = pos - shadow_pos[lo - 1];
                        ans.nearest = (gap_up < gap_down) ? gap_up : gap_down;
                    end
                    if (ans.nearest > shadow_radius)
                        shadow_radius = ans.nearest;
                    if (shadow_radius > peak_radius)
                        peak_radius = shadow_radius;
                end
            end
            default:
                n_unused++;
        endcase
        ans.radius = shadow_radius;
        nearest_answers.push_back(ans);
    endtask

    // drives one item beat and holds it until accepted; valid only drops when a
    // gap is taken, so back-to-back beats never see a low-high pair in one step
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        operation <= op;
        position <= pos;
        do
            @(posedge clk);
        while (!item_ready);
        answer_item(op, pos);
    endtask

    // mix of full-range, clustered, edge and already-stored positions
    function automatic logic [POS_W-1:0] pick_position(input logic [POS_W-1:0] anchor);
        case ($urandom_range(9))
            0, 1, 2, 3: return POS_W'($urandom);
            4, 5, 6: return anchor + POS_W'($urandom_range(0, 64));
            7: return POS_W'($urandom_range(0, 16));
            8: return POS_MAX - POS_W'($urandom_range(0, 16));
            default: return (shadow_count == 0) ? '0
                            : shadow_pos[$urandom_range(0, shadow_count - 1)];
        endcase
    endfunction

    // query on an empty store, unused code, clear of an already empty store
    task automatic test_empty_store();
        send_item(OP_QUERY, '0);
        send_item(OP_QUERY, POS_MAX);
        send_item(OP_UNUSED, POS_MAX);
        send_item(OP_CLEAR, POS_MAX);
    endtask

    // zero is a real stored position, not a sentinel
    task automatic test_position_zero();
        send_item(OP_ADD, '0);
        send_item(OP_QUERY, '0);
        send_item(OP_QUERY, 31'd5);
        send_item(OP_QUERY, POS_MAX);
        send_item(OP_CLEAR, '0);
        send_item(OP_QUERY, 31'd7);
    endtask

    // largest distances, queries either side of the midpoint, duplicates and the unused code with data
    task automatic test_field_extremes();
        send_item(OP_ADD, POS_MAX);
        send_item(OP_QUERY, '0);
        send_item(OP_ADD, '0);
        send_item(OP_QUERY, 31'h3FFF_FFFF);
        send_item(OP_QUERY, 31'h4000_0000);
        send_item(OP_ADD, 31'h4000_0000);
        send_item(OP_ADD, 31'h4000_0000);
        send_item(OP_QUERY, 31'h4000_0001);
        send_item(OP_UNUSED, 31'h5555_5555);
        send_item(OP_QUERY, POS_MAX);
        send_item(OP_QUERY, 31'h2AAA_AAAA);
        send_item(OP_CLEAR, '0);
    endtask

    // sessions of clear then a short burst of adds and queries; stray clears and
    // unused codes break some of them up
    task automatic test_random_sessions(input int n_items);
        int               stop_at;
        int               len;
        int               k;
        logic [POS_W-1:0] anchor;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            anchor = POS_W'($urandom);
            if ($urandom_range(9) != 0)
                send_item(OP_CLEAR, POS_W'($urandom));
            len = $urandom_range(1, 40);
            for (k = 0; k < len; k++)
            begin
                case ($urandom_range(19))
                    0: send_item(OP_UNUSED, POS_W'($urandom));
                    1: send_item(OP_CLEAR, POS_W'($urandom));
                    2, 3, 4, 5, 6, 7, 8, 9, 10: send_item(OP_ADD, pick_position(anchor));
                    default: send_item(OP_QUERY, pick_position(anchor));
                endcase
            end
        end
    endtask

    // fill to capacity, overflow it, query it, then clear
    task automatic test_full_store();
        logic [POS_W-1:0] next_pos;
        int               k;
        send_item(OP_CLEAR, '0);
        // ascending load keeps each insert cheap; a zero step repeats a position
        next_pos = POS_W'($urandom_range(0, 1 << 29));
        for (k = 0; k < STORE_DEPTH - 1; k++)
        begin
            send_item(OP_ADD, next_pos);
            if ($urandom_range(15) == 0)
                send_item(OP_QUERY, pick_position(next_pos));
            next_pos = next_pos + POS_W'($urandom_range(0, 1 << 20));
        end
        // last slot lands near the bottom, so nearly the whole store moves up
        send_item(OP_ADD, POS_W'($urandom_range(0, 1000)));
        send_item(OP_ADD, '0);
        send_item(OP_ADD, POS_MAX);
        send_item(OP_ADD, POS_W'($urandom));
        send_item(OP_QUERY, '0);
        send_item(OP_QUERY, POS_MAX);
        for (k = 0; k < 16; k++)
            send_item(OP_QUERY, pick_position(next_pos));
        send_item(OP_UNUSED, POS_W'($urandom));
        send_item(OP_CLEAR, POS_W'($urandom));
        send_item(OP_QUERY, POS_W'($urandom));
    endtask

    // result side: random backpressure and field-by-field check of each beat
    initial
    begin : result_checker
        nearest_answer_t want;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (nearest_answers.size() == 0)
                    report_mismatch($sformatf(
                        "result beat with nothing owed: status %0d distance %0h radius %0h",
                        status, nearest_distance, radius));
                else
                begin
                    want = nearest_answers.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("beat %0d status: got %0d want %0d",
                            beats_checked, status, want.status));
                    if (nearest_distance !== want.nearest)
                        report_mismatch($sformatf("beat %0d nearest_distance: got %0h want %0h",
                            beats_checked, nearest_distance, want.nearest));
                    if (radius !== want.radius)
                        report_mismatch($sformatf("beat %0d radius: got %0h want %0h",
                            beats_checked, radius, want.radius));
                    beats_checked++;
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ends the run when neither channel has moved a beat for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d results still owed",
                 quiet, nearest_answers.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        item_valid = 1'b0;
        operation = OP_CLEAR;
        position = '0;

        // sender mostly busy, receiver mostly stalling
        send_idle_pct = 10;
        recv_idle_pct = 70;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_position_zero();
        test_field_extremes();
        test_random_sessions(200);

        // sender sparse, receiver mostly ready
        send_idle_pct = 70;
        recv_idle_pct = 10;
        test_random_sessions(200);

        // both sides at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_store();
        test_random_sessions(200);

        item_valid <= 1'b0;
        while (nearest_answers.size() != 0)
            @(posedge clk);
        // room for any stray beat to show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items (%0d clears, %0d adds, %0d queries, %0d unused codes), %0d result beats checked",
                 items_sent, n_clears, n_adds, n_queries, n_unused, beats_checked);
        $display("store reached %0d entries, %0d adds dropped when full, %0d empty-store queries, largest radius %0h",
                 peak_count, n_dropped, n_empty_queries, peak_radius);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
